// ===== design/positional_pid_regulator_unit_defines.svh =====
// assertion macros for the positional pid regulator
// used by the top level only, expects clk and rst in scope
`ifndef POSITIONAL_PID_REGULATOR_UNIT_DEFINES_SVH
`define POSITIONAL_PID_REGULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ppr_pkg.sv =====
// shared types, widths and helpers for the positional pid regulator
// no dependencies
package ppr_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int FRAC_BITS      = 8;
  localparam int GAIN_WIDTH     = 16;
  localparam int TIME_WIDTH     = 32;
  localparam int PERIOD_WIDTH   = 16;
  localparam int DRIVE_WIDTH    = 32;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 32;

  localparam int ERR_WIDTH   = SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH  = GAIN_WIDTH + ERR_WIDTH;
  localparam int TERM_WIDTH  = PROD_WIDTH - FRAC_BITS;
  localparam int SUM_WIDTH   = ((TERM_WIDTH > DRIVE_WIDTH) ? TERM_WIDTH : DRIVE_WIDTH) + 2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_PROP     = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_INTEG    = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_DERIV    = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_INTEG_CEILING = CFG_IDX_WIDTH'(3);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UPDATE_PERIOD = CFG_IDX_WIDTH'(4);

  localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
  localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] measured;
    logic [TIME_WIDTH-1:0]          time_ms;
  } req_t;

  typedef struct packed {
    logic signed [DRIVE_WIDTH-1:0] drive;
    logic                          updated;
  } rsp_t;

  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0]  gain_prop;
    logic signed [GAIN_WIDTH-1:0]  gain_integ;
    logic signed [GAIN_WIDTH-1:0]  gain_deriv;
    logic signed [DRIVE_WIDTH-1:0] integ_ceiling;
    logic [PERIOD_WIDTH-1:0]       update_period;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic [TIME_WIDTH-1:0]          time_ms;
    logic signed [TERM_WIDTH-1:0]   prop_term;
    logic signed [TERM_WIDTH-1:0]   integ_term;
  } front_t;

  function automatic logic signed [DRIVE_WIDTH-1:0] sat_drive(
    input logic signed [SUM_WIDTH-1:0] v
  );
    logic signed [DRIVE_WIDTH-1:0] r;
    if (v > SUM_WIDTH'(DRIVE_MAX)) begin
      r = DRIVE_MAX;
    end else if (v < SUM_WIDTH'(DRIVE_MIN)) begin
      r = DRIVE_MIN;
    end else begin
      r = v[DRIVE_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [TERM_WIDTH-1:0] scale_term(
    input logic signed [GAIN_WIDTH-1:0] gain,
    input logic signed [ERR_WIDTH-1:0]  val
  );
    logic signed [PROD_WIDTH-1:0] prod;
    prod = PROD_WIDTH'(gain) * PROD_WIDTH'(val);
    return prod[PROD_WIDTH-1:FRAC_BITS];
  endfunction

endpackage

// ===== design/ppr_cfg.sv =====
// configuration registers of the positional pid regulator
// depends on ppr_pkg
module ppr_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ppr_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [ppr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  output ppr_pkg::cfg_t                         cfg
);
  import ppr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop     <= '0;
      cfg.gain_integ    <= '0;
      cfg.gain_deriv    <= '0;
      cfg.integ_ceiling <= DRIVE_MAX;
      cfg.update_period <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:     cfg.gain_prop     <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_INTEG:    cfg.gain_integ    <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_DERIV:    cfg.gain_deriv    <= cfg_data[GAIN_WIDTH-1:0];
        REG_INTEG_CEILING: cfg.integ_ceiling <= cfg_data[DRIVE_WIDTH-1:0];
        REG_UPDATE_PERIOD: cfg.update_period <= cfg_data[PERIOD_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/ppr_front.sv =====
// input stage: registers the transaction with its proportional and integral terms
// depends on ppr_pkg
module ppr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            drain,
  input  ppr_pkg::req_t   req,
  input  ppr_pkg::cfg_t   cfg,
  output logic            valid,
  output ppr_pkg::front_t data
);
  import ppr_pkg::*;

  logic signed [ERR_WIDTH-1:0] err;
  front_t                      data_next;

  always_comb begin
    err                  = ERR_WIDTH'(req.target) - ERR_WIDTH'(req.measured);
    data_next.target     = req.target;
    data_next.time_ms    = req.time_ms;
    data_next.prop_term  = scale_term(cfg.gain_prop, err);
    data_next.integ_term = scale_term(cfg.gain_integ, err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/ppr_core.sv =====
// regulator state: update gate, integral accumulator, derivative term and sum
// depends on ppr_pkg
module ppr_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  ppr_pkg::front_t                      data,
  input  ppr_pkg::cfg_t                        cfg,
  output ppr_pkg::rsp_t                        rsp_next,
  output logic signed [ppr_pkg::DRIVE_WIDTH-1:0] held
);
  import ppr_pkg::*;

  logic signed [DRIVE_WIDTH-1:0]  integ_acc;
  logic signed [SAMPLE_WIDTH-1:0] prev_target;
  logic [TIME_WIDTH-1:0]          last_update_ms;
  logic signed [DRIVE_WIDTH-1:0]  held_drive;

  logic [TIME_WIDTH-1:0]          elapsed;
  logic                           due;
  logic signed [SUM_WIDTH-1:0]    acc_sum;
  logic signed [DRIVE_WIDTH-1:0]  integ_acc_next;
  logic signed [ERR_WIDTH-1:0]    target_diff;
  logic signed [TERM_WIDTH-1:0]   deriv_term;
  logic signed [SUM_WIDTH-1:0]    drive_sum;
  logic signed [DRIVE_WIDTH-1:0]  held_drive_next;

  always_comb begin
    elapsed     = data.time_ms - last_update_ms;
    due         = elapsed >= TIME_WIDTH'(cfg.update_period);
    acc_sum     = SUM_WIDTH'(integ_acc) + SUM_WIDTH'(data.integ_term);
    if (integ_acc < cfg.integ_ceiling) begin
      integ_acc_next = sat_drive(acc_sum);
    end else begin
      integ_acc_next = integ_acc;
    end
    target_diff = ERR_WIDTH'(prev_target) - ERR_WIDTH'(data.target);
    deriv_term  = scale_term(cfg.gain_deriv, target_diff);
    drive_sum   = SUM_WIDTH'(data.prop_term) + SUM_WIDTH'(deriv_term);
    if (cfg.gain_integ != '0) begin
      drive_sum = drive_sum + SUM_WIDTH'(integ_acc_next);
    end
    held_drive_next  = due ? sat_drive(drive_sum) : held_drive;
    rsp_next.drive   = held_drive_next;
    rsp_next.updated = due;
  end

  assign held = held_drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc      <= '0;
      prev_target    <= '0;
      last_update_ms <= '0;
      held_drive     <= '0;
    end else if (step && due) begin
      integ_acc      <= integ_acc_next;
      prev_target    <= data.target;
      last_update_ms <= data.time_ms;
      held_drive     <= held_drive_next;
    end
  end

endmodule

// ===== design/positional_pid_regulator_unit.sv =====
// top level of the positional pid regulator
// depends on ppr_pkg, ppr_cfg, ppr_front, ppr_core and the assertion macro header
// req channel: req_valid/req_stall carry target, measured and a wrapping ms time stamp
// rsp channel: rsp_valid/rsp_stall carry the drive and an updated flag, one per request
// cfg port: cfg_we writes cfg_data to register cfg_index (0 prop gain, 1 integral gain,
//   2 derivative gain, 3 integral ceiling, 4 update period); other indexes are ignored
// a request is registered in the input stage, and its response then in the output register
// throughput: one transaction per cycle while rsp_stall is low; the state loop
//   (gate, accumulator, derivative multiply and saturating sum) updates with the output register
// update: when the time since the last update reaches the period the drive is recomputed,
//   otherwise the held drive is repeated with updated low
// reset: gains and period clear, ceiling goes to the largest positive value, regulator
//   state and both pipeline stages empty
// stall: a stalled response holds; one more request is taken into the input stage,
//   after which req_stall rises until the response is taken
module positional_pid_regulator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  ppr_pkg::req_t                      req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output ppr_pkg::rsp_t                      rsp,
  input  logic                               cfg_we,
  input  logic [ppr_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [ppr_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import ppr_pkg::*;

  `include "positional_pid_regulator_unit_defines.svh"

  cfg_t                          cfg;
  front_t                        front_data;
  logic                          front_valid;
  logic                          advance;
  logic                          drain;
  logic                          load;
  rsp_t                          rsp_next;
  logic signed [DRIVE_WIDTH-1:0] held;
  logic                          period_zero;

  assign advance   = !rsp_valid || !rsp_stall;
  assign drain     = front_valid && advance;
  assign req_stall = front_valid && !advance;
  assign load      = req_valid && !req_stall;

  ppr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppr_front u_front (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .drain (drain),
    .req   (req),
    .cfg   (cfg),
    .valid (front_valid),
    .data  (front_data)
  );

  ppr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (drain),
    .data     (front_data),
    .cfg      (cfg),
    .rsp_next (rsp_next),
    .held     (held)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (drain) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      rsp <= rsp_next;
    end
  end

  assign period_zero = (cfg.update_period == '0);

  `PPR_ASSERT_NOW(a_rsp_matches_held, rsp_valid, rsp.drive == held, "drive differs from held")
  `PPR_ASSERT_NOW(a_zero_period_updates, drain && period_zero, rsp_next.updated, "missed update")
  `PPR_ASSERT_NOW(a_empty_front_no_stall, !front_valid, !req_stall, "stall while empty")
  `PPR_ASSERT_NEXT(a_drain_fills_rsp, drain, rsp_valid, "response not loaded")

endmodule
